// ===== design/ddnms_pkg.sv =====
// ----------------------------------------------------------------------------
// ddnms_pkg
// Shared types, constants and codes for the per-class detection decoder.
// ----------------------------------------------------------------------------
package ddnms_pkg;

  // Store and frame limits
  localparam int MAX_CAND   = 512;
  localparam int CAND_AW    = $clog2(MAX_CAND);
  localparam int CNT_W      = CAND_AW + 1;
  localparam int CLASSES    = 16;
  localparam int CLS_W      = 4;
  localparam int MAX_DET    = 64;
  localparam int DET_W      = 7;
  localparam int EDGE_STEPS = 4;

  // Edge rounding: Q.17 product back to Q12.4, half up
  localparam int RND_ADD   = 4096;
  localparam int RND_SHIFT = 13;

  // Configuration reset values
  localparam logic [15:0] CONF_RST = 16'd16384;
  localparam logic [15:0] IOU_RST  = 16'd29491;
  localparam logic [6:0]  MAXD_RST = 7'd64;
  localparam logic [15:0] INVR_RST = 16'd4096;
  localparam logic [11:0] IMG_RST  = 12'd960;

  typedef enum logic [2:0] {
    CFG_CONF,
    CFG_IOU,
    CFG_MAXDET,
    CFG_PADL,
    CFG_PADT,
    CFG_INVR,
    CFG_IMGW,
    CFG_IMGH
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IN,
    S_EDGE,
    S_STORE,
    S_FIND_INIT,
    S_FIND,
    S_NEXT,
    S_PICK,
    S_SUP,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [3:0]  class_index;
    logic [15:0] class_score;
    logic        last_of_anchor;
    logic        last_of_frame;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] score;
    logic [3:0]  det_cls;
    logic        overflow;
    logic        last;
  } out_item_t;

  // One candidate store word
  typedef struct packed {
    logic [15:0]      score;
    logic [CLS_W-1:0] cls;
    logic [15:0]      l;
    logic [15:0]      t;
    logic [15:0]      r;
    logic [15:0]      b;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       edge_mul;
    logic [1:0] edge_sel;
    logic       edge_post;
    logic       store;
    logic       scan_start;
    logic       scan_sup;
    logic       cls_inc;
    logic       pick;
    logic       flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fire;
    logic close;
    logic cand;
    logic full;
    logic frame;
    logic frame_q;
    logic scan_busy;
    logic found;
    logic cls_last;
    logic cap_hit;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

// ===== design/ddnms_if.sv =====
// ----------------------------------------------------------------------------
// ddnms_in_if / ddnms_out_if
// Valid/ready channels carrying score words in and detection words out.
// ----------------------------------------------------------------------------
interface ddnms_in_if;
  logic                 valid;
  logic                 ready;
  ddnms_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ddnms_out_if;
  logic                 valid;
  logic                 ready;
  ddnms_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/detection_decode_per_class_nms.sv =====
// ----------------------------------------------------------------------------
// detection_decode_per_class_nms
// Box decoder with per-class greedy non-maximum suppression.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one class-score word per cycle while ready is high, grouped
//   by anchor; the word that closes an anchor also carries its box. An
//   ordinary word is taken without stalling the input. An anchor that
//   becomes a candidate holds ready low while the four corner edges go one
//   at a time through one 20x17 multiplier and a round/clip stage, then the
//   store is written. At frame end the input stalls while the NMS pass runs
//   over the candidate store (n entries, one read a cycle): per class a
//   max-search scan, and per kept box a suppression scan. out_o gives the
//   results class ascending, last set on the final one; an empty frame gives
//   one word with valid_res clear. A stall on out_o holds the result in the
//   output register and pauses the NMS pass. cfg_we_i/cfg_idx_i/cfg_data_i
//   write configuration; the user must write only while idle, since the
//   block itself does not enforce it. Reset restores default configuration
//   and empties the store; the store memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module detection_decode_per_class_nms (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddnms_in_if.sink    in_i,
  ddnms_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  ddnms_pkg::cmd_t cmd;
  ddnms_pkg::sts_t sts;

  ddnms_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ddnms_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// ===== design/ddnms_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddnms_ctrl
// Sequencer: input intake, edge mapping steps, per-class pick/suppress scans.
// ----------------------------------------------------------------------------
module ddnms_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddnms_pkg::sts_t    sts_i,
  output ddnms_pkg::cmd_t    cmd_o
);

  ddnms_pkg::state_e state_q, state_d;
  logic [2:0]        step_q, step_d;

  // State and step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddnms_pkg::S_IN;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign step_d = (state_q == ddnms_pkg::S_EDGE) ? step_q + 3'd1 : 3'd0;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ddnms_pkg::S_IN: begin
        if (sts_i.fire) begin
          if (sts_i.close && sts_i.cand && !sts_i.full) state_d = ddnms_pkg::S_EDGE;
          else if (sts_i.frame)                         state_d = ddnms_pkg::S_FIND_INIT;
        end
      end
      ddnms_pkg::S_EDGE: begin
        if (step_q == 3'(ddnms_pkg::EDGE_STEPS)) state_d = ddnms_pkg::S_STORE;
      end
      ddnms_pkg::S_STORE:
        state_d = sts_i.frame_q ? ddnms_pkg::S_FIND_INIT : ddnms_pkg::S_IN;
      ddnms_pkg::S_FIND_INIT:
        state_d = sts_i.cap_hit ? ddnms_pkg::S_FLUSH : ddnms_pkg::S_FIND;
      ddnms_pkg::S_FIND: begin
        if (!sts_i.scan_busy) state_d = sts_i.found ? ddnms_pkg::S_PICK : ddnms_pkg::S_NEXT;
      end
      ddnms_pkg::S_NEXT:
        state_d = sts_i.cls_last ? ddnms_pkg::S_FLUSH : ddnms_pkg::S_FIND_INIT;
      ddnms_pkg::S_PICK: begin
        if (!sts_i.pend_valid || sts_i.out_free) state_d = ddnms_pkg::S_SUP;
      end
      ddnms_pkg::S_SUP: begin
        if (!sts_i.scan_busy) state_d = ddnms_pkg::S_FIND_INIT;
      end
      ddnms_pkg::S_FLUSH: begin
        if (sts_i.out_free) state_d = ddnms_pkg::S_IN;
      end
      default: state_d = ddnms_pkg::S_IN;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ddnms_pkg::S_IN: cmd_o.accept = 1'b1;
      ddnms_pkg::S_EDGE: begin
        cmd_o.edge_mul  = (step_q < 3'(ddnms_pkg::EDGE_STEPS));
        cmd_o.edge_sel  = step_q[1:0];
        cmd_o.edge_post = (step_q != 3'd0);
      end
      ddnms_pkg::S_STORE: cmd_o.store = 1'b1;
      ddnms_pkg::S_FIND_INIT: cmd_o.scan_start = !sts_i.cap_hit;
      ddnms_pkg::S_FIND: ;
      ddnms_pkg::S_NEXT: cmd_o.cls_inc = !sts_i.cls_last;
      ddnms_pkg::S_PICK: begin
        if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.pick       = 1'b1;
          cmd_o.scan_start = 1'b1;
          cmd_o.scan_sup   = 1'b1;
        end
      end
      ddnms_pkg::S_SUP: ;
      ddnms_pkg::S_FLUSH: cmd_o.flush = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/ddnms_dp.sv =====
// ----------------------------------------------------------------------------
// ddnms_dp
// Datapath: config registers, best-class tracking, edge mapper, candidate
// store, scan pipeline for max search and overlap test, output register.
// ----------------------------------------------------------------------------
module ddnms_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  ddnms_in_if.sink         in_i,
  ddnms_out_if.source      out_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  ddnms_pkg::cmd_t  cmd_i,
  output ddnms_pkg::sts_t  sts_o
);

  localparam int AW = ddnms_pkg::CAND_AW;
  localparam int CW = ddnms_pkg::CNT_W;

  // Configuration registers
  logic [15:0] conf_q, iou_q, padl_q, padt_q, invr_q;
  logic [6:0]  maxd_q;
  logic [11:0] imgw_q, imgh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q <= ddnms_pkg::CONF_RST;
      iou_q  <= ddnms_pkg::IOU_RST;
      maxd_q <= ddnms_pkg::MAXD_RST;
      padl_q <= '0;
      padt_q <= '0;
      invr_q <= ddnms_pkg::INVR_RST;
      imgw_q <= ddnms_pkg::IMG_RST;
      imgh_q <= ddnms_pkg::IMG_RST;
    end else if (cfg_we_i) begin
      unique case (ddnms_pkg::cfg_idx_e'(cfg_idx_i))
        ddnms_pkg::CFG_CONF:   conf_q <= cfg_data_i;
        ddnms_pkg::CFG_IOU:    iou_q  <= cfg_data_i;
        ddnms_pkg::CFG_MAXDET: maxd_q <= cfg_data_i[6:0];
        ddnms_pkg::CFG_PADL:   padl_q <= cfg_data_i;
        ddnms_pkg::CFG_PADT:   padt_q <= cfg_data_i;
        ddnms_pkg::CFG_INVR:   invr_q <= cfg_data_i;
        ddnms_pkg::CFG_IMGW:   imgw_q <= cfg_data_i[11:0];
        ddnms_pkg::CFG_IMGH:   imgh_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Best class of the open anchor
  ddnms_pkg::in_item_t item;
  logic        fire, upd, close, cand, full, nbv;
  logic [15:0] bs_q, nbs;
  logic [3:0]  bc_q, nbc;
  logic        bv_q, ovf_q, frame_q;
  logic [CW-1:0] cnt_q;

  assign item  = in_i.data;
  assign fire  = in_i.valid && cmd_i.accept;
  assign in_i.ready = cmd_i.accept;
  assign upd   = (5'(item.class_index) < 5'(ddnms_pkg::CLASSES)) && (item.class_score > bs_q);
  assign nbs   = upd ? item.class_score : bs_q;
  assign nbc   = upd ? item.class_index : bc_q;
  assign nbv   = upd || bv_q;
  assign close = item.last_of_anchor || item.last_of_frame;
  assign cand  = nbv && (nbs >= conf_q);
  assign full  = (cnt_q == CW'(ddnms_pkg::MAX_CAND));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q    <= '0;
      bv_q    <= 1'b0;
      ovf_q   <= 1'b0;
      frame_q <= 1'b0;
    end else begin
      if (fire) begin
        bs_q    <= close ? 16'd0 : nbs;
        bv_q    <= close ? 1'b0 : nbv;
        frame_q <= item.last_of_frame;
        if (close && cand && full) ovf_q <= 1'b1;
      end
      if (cmd_i.flush) ovf_q <= 1'b0;
    end
  end

  // Box and winner of a closing anchor
  logic [15:0] cx_q, cy_q, w_q, h_q, cs_q;
  logic [3:0]  cc_q;

  always_ff @(posedge clk_i) begin
    if (fire) bc_q <= nbc;
    if (fire && close) begin
      cx_q <= item.center_x;
      cy_q <= item.center_y;
      w_q  <= item.box_width;
      h_q  <= item.box_height;
      cs_q <= nbs;
      cc_q <= nbc;
    end
  end

  // Edge mapper: multiply step, then round and clip step
  logic [15:0]        ec, es, ep;
  logic signed [19:0] ev;
  logic signed [36:0] prod_q;
  logic [1:0]         psel_q;
  logic [36:0]        rsum;
  logic [23:0]        rq;
  logic [15:0]        lim, post;
  logic [15:0]        e_q [ddnms_pkg::EDGE_STEPS];

  assign ec = cmd_i.edge_sel[0] ? cy_q : cx_q;
  assign es = cmd_i.edge_sel[0] ? h_q : w_q;
  assign ep = cmd_i.edge_sel[0] ? padt_q : padl_q;
  assign ev = $signed({3'b000, ec, 1'b0})
            + (cmd_i.edge_sel[1] ? $signed({4'b0000, es}) : -$signed({4'b0000, es}))
            - $signed({3'b000, ep, 1'b0});

  assign rsum = 37'(prod_q) + 37'(ddnms_pkg::RND_ADD);
  assign rq   = rsum[ddnms_pkg::RND_SHIFT +: 24];
  assign lim  = {(psel_q[0] ? imgh_q : imgw_q), 4'b0000};

  always_comb begin
    if (prod_q <= 37'sd0)        post = '0;
    else if (rq > {8'd0, lim})   post = lim;
    else                         post = rq[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_mul) begin
      prod_q <= ev * $signed({1'b0, invr_q});
      psel_q <= cmd_i.edge_sel;
    end
    if (cmd_i.edge_post) e_q[psel_q] <= post;
  end

  // Candidate store and done marks
  ddnms_pkg::entry_t cmem [ddnms_pkg::MAX_CAND];
  logic              dmem [ddnms_pkg::MAX_CAND];
  ddnms_pkg::entry_t new_e, rd_q, fb_q, pend_q;
  logic              dn_q;
  logic [AW-1:0]     addr_q, i0_q, i1_q, i2_q, i3_q, i4_q, fb_idx_q;
  logic              run_q, sup_q, v0_q, v1_q, v2_q, v3_q, v4_q;
  logic              dwe, dwd, sup_hit;
  logic [AW-1:0]     dwa;

  assign new_e = '{score: cs_q, cls: cc_q, l: e_q[0], t: e_q[1], r: e_q[2], b: e_q[3]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) cmem[cnt_q[AW-1:0]] <= new_e;
    if (run_q)       rd_q <= cmem[addr_q];
  end

  // One done-mark write a cycle: clear on store, set on pick or suppression
  always_comb begin
    dwe = 1'b0;
    dwa = fb_idx_q;
    dwd = 1'b1;
    priority if (cmd_i.store) begin
      dwe = 1'b1;
      dwa = cnt_q[AW-1:0];
      dwd = 1'b0;
    end else if (cmd_i.pick) begin
      dwe = 1'b1;
    end else if (sup_hit) begin
      dwe = 1'b1;
      dwa = i4_q;
    end else begin
      dwe = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dwe)   dmem[dwa] <= dwd;
    if (run_q) dn_q <= dmem[addr_q];
  end

  // Counters
  localparam int CLS_WL = ddnms_pkg::CLS_W;
  logic [CLS_WL-1:0] cls_q;
  logic [6:0] emit_q, cap;
  logic       pend_v_q, ov_q;

  assign cap = (maxd_q > 7'(ddnms_pkg::MAX_DET)) ? 7'(ddnms_pkg::MAX_DET) : maxd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      cls_q    <= '0;
      emit_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      if (cmd_i.store)   cnt_q  <= cnt_q + CW'(1);
      if (cmd_i.cls_inc) cls_q  <= cls_q + CLS_WL'(1);
      if (cmd_i.pick) begin
        emit_q   <= emit_q + 7'd1;
        pend_v_q <= 1'b1;
      end
      if (cmd_i.flush) begin
        cnt_q    <= '0;
        cls_q    <= '0;
        emit_q   <= '0;
        pend_v_q <= 1'b0;
      end
    end
  end

  // Scan address generator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      sup_q  <= 1'b0;
      addr_q <= '0;
    end else if (cmd_i.scan_start) begin
      run_q  <= (cnt_q != '0);
      sup_q  <= cmd_i.scan_sup;
      addr_q <= '0;
    end else if (run_q) begin
      addr_q <= addr_q + AW'(1);
      if (({1'b0, addr_q} + CW'(1)) == cnt_q) run_q <= 1'b0;
    end
  end

  // Scan pipeline valids
  logic elig;
  assign elig = v0_q && (rd_q.cls == cls_q) && !dn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= run_q;
      v1_q <= elig && sup_q && (i0_q != fb_idx_q);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Max search over eligible entries, earliest wins ties
  always_ff @(posedge clk_i) begin
    i0_q <= addr_q;
    if (cmd_i.scan_start && !cmd_i.scan_sup) fb_q.score <= '0;
    else if (elig && !sup_q && (rd_q.score > fb_q.score)) begin
      fb_q     <= rd_q;
      fb_idx_q <= i0_q;
    end
  end

  // Overlap test: intersect, multiply, union, scale, compare
  logic [15:0] ix1, iy1, ix2, iy2;
  logic [15:0] iw_q, ih_q, ew_q, eh_q, bw_q, bh_q;
  logic [31:0] inter_q, a1_q, a2_q, inter3_q;
  logic [32:0] uni_q;
  logic [48:0] thp_q;
  logic [47:0] int4_q;

  assign ix1 = (fb_q.l > rd_q.l) ? fb_q.l : rd_q.l;
  assign iy1 = (fb_q.t > rd_q.t) ? fb_q.t : rd_q.t;
  assign ix2 = (fb_q.r < rd_q.r) ? fb_q.r : rd_q.r;
  assign iy2 = (fb_q.b < rd_q.b) ? fb_q.b : rd_q.b;

  always_ff @(posedge clk_i) begin
    i1_q     <= i0_q;
    iw_q     <= (ix2 > ix1) ? ix2 - ix1 : 16'd0;
    ih_q     <= (iy2 > iy1) ? iy2 - iy1 : 16'd0;
    ew_q     <= rd_q.r - rd_q.l;
    eh_q     <= rd_q.b - rd_q.t;
    bw_q     <= fb_q.r - fb_q.l;
    bh_q     <= fb_q.b - fb_q.t;
    i2_q     <= i1_q;
    inter_q  <= iw_q * ih_q;
    a1_q     <= bw_q * bh_q;
    a2_q     <= ew_q * eh_q;
    i3_q     <= i2_q;
    uni_q    <= {1'b0, a1_q} + {1'b0, a2_q} - {1'b0, inter_q};
    inter3_q <= inter_q;
    i4_q     <= i3_q;
    thp_q    <= iou_q * uni_q;
    int4_q   <= {inter3_q, 16'd0};
  end

  assign sup_hit = v4_q && ({1'b0, int4_q} > thp_q);

  // Pending result and output register
  ddnms_pkg::out_item_t out_q;
  logic                 out_free;

  assign out_free = !ov_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) pend_q <= fb_q;
    if ((cmd_i.pick && pend_v_q) || cmd_i.flush) begin
      out_q.valid_res <= pend_v_q;
      out_q.left      <= pend_v_q ? pend_q.l : 16'd0;
      out_q.top       <= pend_v_q ? pend_q.t : 16'd0;
      out_q.right     <= pend_v_q ? pend_q.r : 16'd0;
      out_q.bottom    <= pend_v_q ? pend_q.b : 16'd0;
      out_q.score     <= pend_v_q ? pend_q.score : 16'd0;
      out_q.det_cls   <= pend_v_q ? pend_q.cls : 4'd0;
      out_q.overflow  <= ovf_q;
      out_q.last      <= cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                                          ov_q <= 1'b0;
    else if ((cmd_i.pick && pend_v_q) || cmd_i.flush)     ov_q <= 1'b1;
    else if (out_o.ready)                                 ov_q <= 1'b0;
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

  // Status
  assign sts_o.fire       = fire;
  assign sts_o.close      = close;
  assign sts_o.cand       = cand;
  assign sts_o.full       = full;
  assign sts_o.frame      = item.last_of_frame;
  assign sts_o.frame_q    = frame_q;
  assign sts_o.scan_busy  = run_q || v0_q || v1_q || v2_q || v3_q || v4_q;
  assign sts_o.found      = (fb_q.score != 16'd0);
  assign sts_o.cls_last   = (cls_q == CLS_WL'(ddnms_pkg::CLASSES - 1));
  assign sts_o.cap_hit    = (emit_q >= cap);
  assign sts_o.pend_valid = pend_v_q;
  assign sts_o.out_free   = out_free;

endmodule

// ===== design/ddnms_checker.sv =====
// ----------------------------------------------------------------------------
// ddnms_checker
// Port-level checks on the detection word stream.
// ----------------------------------------------------------------------------
module ddnms_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input ddnms_pkg::out_item_t out_data_i
);

  // A stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // Empty-frame marker is always the final word
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.valid_res |-> out_data_i.last)
    else $error("empty marker without last");

  // Empty-frame marker carries zero left, right, score and class
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.valid_res |->
      out_data_i.left == 16'd0 && out_data_i.right == 16'd0 &&
      out_data_i.score == 16'd0 && out_data_i.det_cls == 4'd0)
    else $error("empty marker with payload");

  // Mapped boxes keep their corner order
  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.valid_res |->
      out_data_i.left <= out_data_i.right && out_data_i.top <= out_data_i.bottom)
    else $error("box corners out of order");

endmodule

bind detection_decode_per_class_nms ddnms_checker u_ddnms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
